// ===== rtl/olc_pkg.sv =====
`default_nettype none
package olc_pkg;
  localparam int unsigned CoordW = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned DistW  = 35;
  localparam int unsigned IdxOutW = 6;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
  } point_t;

  typedef struct packed {
    logic              vld;
    point_t            c;
    logic [CountW-1:0] n;
  } entry_t;

  function automatic logic [2*CoordW-1:0] sq_diff(input logic [CoordW-1:0] a,
                                                   input logic [CoordW-1:0] b);
    logic [CoordW-1:0] d;
    d = (a > b) ? a - b : b - a;
    return {{CoordW{1'b0}}, d} * {{CoordW{1'b0}}, d};
  endfunction
endpackage
`default_nettype wire

// ===== rtl/olc_cell.sv =====
`default_nettype none
// One cluster slot. Entries rotate through the ring of cells; the head cell
// sees the entry that leaves the tail.
module olc_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           clear_i,
  input  wire logic           load_i,
  input  wire olc_pkg::entry_t load_val_i,
  input  wire olc_pkg::entry_t prev_i,
  output olc_pkg::entry_t     cur_o
);
  logic                       vld_q;
  olc_pkg::point_t            c_q;
  logic [olc_pkg::CountW-1:0] n_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (clear_i) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= load_val_i.vld;
    end else begin
      vld_q <= prev_i.vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      c_q <= load_val_i.c;
      n_q <= load_val_i.n;
    end else begin
      c_q <= prev_i.c;
      n_q <= prev_i.n;
    end
  end
  assign cur_o = '{vld: vld_q, c: c_q, n: n_q};
endmodule
`default_nettype wire

// ===== rtl/olc_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module olc_div #(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quo_q;
  logic [DenW:0]   rem_q;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DenW:0]   shl;
  always_comb shl = {rem_q[DenW-1:0], quo_q[NumW-1]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (shl >= {1'b0, den_q}) begin
        rem_q <= shl - {1'b0, den_q};
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= shl;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end
  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

// ===== rtl/online_leader_clustering.sv =====
`default_nettype none
// One point at a time; the next beat is taken once the block is idle and the result
// register is free. The shared 32-step divider runs once per coordinate on a join.
// Reset (async, active low) empties all slots and loads join_distance 3840.
module online_leader_clustering #(
  parameter int unsigned MAX_CLUSTERS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // x[15:0], y[31:16], z[47:32]
  input  wire logic [47:0] s_axis_tdata,
  // first_of_set
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // cluster_index[5:0], member_count[21:6], cx[37:22], cy[53:38], cz[69:54]
  output logic [71:0]      m_axis_tdata,
  // opened_new[0], table_full[1]
  output logic [1:0]       m_axis_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  localparam int unsigned N  = MAX_CLUSTERS;
  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned UW = $clog2(N + 1);
  localparam int unsigned SW = $clog2(N + 2);
  localparam int unsigned NW = 32;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_DIV, S_WB, S_OUT} state_e;
  typedef enum logic [1:0] {DX, DY, DZ} axis_e;

  state_e state_q;
  axis_e  axis_q;
  logic [15:0] jd_q;
  logic [31:0] limit_q;
  olc_pkg::point_t p_q;
  logic [UW-1:0] used_q;
  logic [IW-1:0] pos_q, best_q;
  logic [olc_pkg::DistW-1:0] bestd_q;
  logic found_q;
  logic [1:0] sub_q;
  logic [SW-1:0] scan_q;
  logic scan_issue;
  logic [olc_pkg::DistW-1:0] dist_q;
  logic dist_vld_q;
  logic [IW-1:0] dist_pos_q;
  logic dist_vld_pipe;
  logic [IW-1:0] dist_pos2;
  olc_pkg::entry_t upd_q;
  logic join_q, wb_load_q;
  logic [IW-1:0] wb_tgt_q;
  logic [IW-1:0] wb_prev;
  logic [2*olc_pkg::CoordW-1:0] sq_q [3];
  logic [NW-1:0] num_q;
  logic div_start_q;
  logic div_done;
  logic [NW-1:0] div_quo;
  logic [71:0] out_data_q;
  logic [1:0]  out_user_q;
  logic        out_vld_q;

  olc_pkg::entry_t ring [N];
  olc_pkg::entry_t head_in;
  logic clear_q;

  assign head_in = ring[N-1];
  for (genvar g = 0; g < N; g++) begin : g_cell
    olc_cell u_cell (
      .clk_i, .rst_ni,
      .clear_i(clear_q),
      .load_i(g == 0 && wb_load_q && pos_q == wb_tgt_q),
      .load_val_i(upd_q),
      .prev_i((g == 0) ? head_in : ring[(g == 0) ? 0 : g-1]),
      .cur_o(ring[g])
    );
  end

  olc_div #(.NumW(NW), .DenW(olc_pkg::CountW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start_q), .num_i(num_q),
    .den_i(upd_q.n), .done_o(div_done), .quo_o(div_quo)
  );

  logic [olc_pkg::CoordW-1:0] cc, pc;
  always_comb begin
    case (axis_q)
      DX: begin cc = upd_q.c.x; pc = p_q.x; end
      DY: begin cc = upd_q.c.y; pc = p_q.y; end
      default: begin cc = upd_q.c.z; pc = p_q.z; end
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE) && !out_vld_q && !clear_q;
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_user_q;
  assign scan_issue = (state_q == S_SCAN) && (scan_q < SW'(N));
  assign wb_prev = (wb_tgt_q == '0) ? IW'(N-1) : wb_tgt_q - 1'b1;

  // The ring head (ring[N-1]) holds slot pos_q; rotation advances it by one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      jd_q <= 16'd3840;
      used_q <= '0;
      pos_q <= '0;
      clear_q <= 1'b0;
      out_vld_q <= 1'b0;
      out_data_q <= '0;
      out_user_q <= '0;
      div_start_q <= 1'b0;
      wb_load_q <= 1'b0;
    end else begin
      clear_q <= 1'b0;
      div_start_q <= 1'b0;
      if (cfg_valid) jd_q <= cfg_data;
      if (out_vld_q && m_axis_tready) out_vld_q <= 1'b0;
      pos_q <= (pos_q == IW'(N-1)) ? '0 : pos_q + 1'b1;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            p_q <= '{x: s_axis_tdata[15:0], y: s_axis_tdata[31:16],
                     z: s_axis_tdata[47:32]};
            limit_q <= jd_q * jd_q;
            found_q <= 1'b0;
            sub_q <= '0;
            scan_q <= '0;
            if (s_axis_tuser) begin
              used_q <= '0;
              clear_q <= 1'b1;
            end
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (dist_vld_pipe && (!found_q || dist_q < bestd_q ||
              (dist_q == bestd_q && dist_pos2 < best_q))) begin
            found_q <= 1'b1;
            bestd_q <= dist_q;
            best_q <= dist_pos2;
          end
          scan_q <= scan_q + 1'b1;
          if (scan_q == SW'(N + 1)) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (!found_q || bestd_q > olc_pkg::DistW'(limit_q)) begin
            if (used_q >= UW'(N)) begin
              out_data_q <= '0;
              out_user_q <= 2'b10;
              out_vld_q <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              join_q <= 1'b0;
              wb_tgt_q <= IW'(used_q);
              upd_q <= '{vld: 1'b1, c: p_q, n: 16'd1};
              used_q <= used_q + 1'b1;
              state_q <= S_WB;
            end
          end else begin
            join_q <= 1'b1;
            wb_tgt_q <= best_q;
            upd_q.vld <= 1'b0;
            state_q <= S_WB;
          end
        end
        S_WB: begin
          if (join_q && !upd_q.vld) begin
            if (pos_q == best_q) begin
              upd_q <= '{vld: 1'b1, c: head_in.c,
                         n: (head_in.n != olc_pkg::CountMax) ? head_in.n + 1'b1
                                                             : head_in.n};
              axis_q <= DX;
              state_q <= S_DIV;
              sub_q <= 2'd3;
            end
          end else if (!wb_load_q) begin
            if (pos_q == wb_prev || (N == 1)) wb_load_q <= 1'b1;
          end else begin
            wb_load_q <= 1'b0;
            out_data_q <= {2'b0, upd_q.c.z, upd_q.c.y, upd_q.c.x, upd_q.n,
                           olc_pkg::IdxOutW'(wb_tgt_q)};
            out_user_q <= {1'b0, !join_q};
            state_q <= S_OUT;
          end
        end
        S_DIV: begin
          if (sub_q == 2'd3) begin
            num_q <= {16'd0, cc} * {16'd0, upd_q.n - 1'b1} + {16'd0, pc};
            div_start_q <= 1'b1;
            sub_q <= 2'd0;
          end else if (div_done) begin
            sub_q <= 2'd3;
            case (axis_q)
              DX: begin upd_q.c.x <= div_quo[15:0]; axis_q <= DY; end
              DY: begin upd_q.c.y <= div_quo[15:0]; axis_q <= DZ; end
              default: begin upd_q.c.z <= div_quo[15:0]; state_q <= S_WB; end
            endcase
          end
        end
        S_OUT: begin
          out_vld_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Scan pipeline: square, sum, then compare in the state machine.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_vld_q <= 1'b0;
      dist_vld_pipe <= 1'b0;
    end else begin
      dist_vld_q <= scan_issue && head_in.vld && (UW'(pos_q) < used_q);
      dist_vld_pipe <= dist_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    sq_q[0] <= olc_pkg::sq_diff(p_q.x, head_in.c.x);
    sq_q[1] <= olc_pkg::sq_diff(p_q.y, head_in.c.y);
    sq_q[2] <= olc_pkg::sq_diff(p_q.z, head_in.c.z);
    dist_pos_q <= pos_q;
    dist_q <= olc_pkg::DistW'(sq_q[0]) + olc_pkg::DistW'(sq_q[1])
            + olc_pkg::DistW'(sq_q[2]);
    dist_pos2 <= dist_pos_q;
  end
endmodule
`default_nettype wire

// ===== rtl/olc_checker.sv =====
`default_nettype none
module olc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [71:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("opened and full");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 72'd0)
    else $error("full result not zero");
  a_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[21:6] == 16'd1)
    else $error("new cluster count");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken");
endmodule
bind online_leader_clustering olc_checker u_olc_checker (.*);
`default_nettype wire
